// ----- rtl/bal_pkg.sv -----
// ============================================================================
// Bounded array list package
// Shared constants, request and result types, and the cell control word.
// ============================================================================
package bal_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RDVAL_W  = 32;
    localparam int COUNT_W  = 5;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_ERASE
    } cell_mode_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RDVAL_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
    } result_t;

    typedef struct packed {
        cell_mode_t             mode;
        logic [IDX_W-1:0]       target;
        logic [DATA_WIDTH-1:0]  data;
    } cell_ctrl_t;

endpackage

// ----- rtl/bal_cell.sv -----
// ============================================================================
// Bounded array list cell
// Holds one list entry and takes its neighbour's entry on a shift.
// ============================================================================
module bal_cell (
    input  logic                           clk,
    input  logic [bal_pkg::IDX_W-1:0]      index,
    input  bal_pkg::cell_ctrl_t            ctrl,
    input  logic [bal_pkg::DATA_WIDTH-1:0] left_data,
    input  logic [bal_pkg::DATA_WIDTH-1:0] right_data,
    output logic [bal_pkg::DATA_WIDTH-1:0] data
);

    logic [bal_pkg::DATA_WIDTH-1:0] data_reg;
    logic [bal_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            bal_pkg::CELL_APPEND:
            begin
                if (index == ctrl.target)
                begin
                    data_next = ctrl.data;
                end
            end
            bal_pkg::CELL_INSERT:
            begin
                if (index == ctrl.target)
                begin
                    data_next = ctrl.data;
                end
                else if (index > ctrl.target)
                begin
                    data_next = left_data;
                end
            end
            bal_pkg::CELL_ERASE:
            begin
                if (index >= ctrl.target)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/bounded_array_list_core.sv -----
// ============================================================================
// Bounded array list core
// Fixed-capacity ordered list built as a row of entry cells.
// ============================================================================
// A request is taken when start is high and busy is low; busy never rises,
// so a new request may be issued in every cycle. Each request is append,
// insert at a 0-based position, erase at a 1-based position, read at a
// 0-based position or clear.
// Exactly one result follows each request, in the cycle after it is taken:
// done is high for that single cycle and result carries the status, the
// value read and the entry count after the operation.
// Throughput is one request per cycle: every cell takes its new entry from
// itself, a neighbour or the request in the same cycle, so the whole list
// shifts together.
// The receiver cannot stall; a result must be taken in its done cycle.
// Reset clears the entry count and the result strobe; the stored entries
// keep whatever they held and are only readable once written again.
// ============================================================================
module bounded_array_list_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bal_pkg::request_t request,
    output logic              done,
    output bal_pkg::result_t  result
);

    logic [bal_pkg::CNT_W-1:0] cnt_reg;
    logic [bal_pkg::CNT_W-1:0] cnt_next;
    logic                      done_reg;
    bal_pkg::result_t          result_reg;
    bal_pkg::result_t          result_next;

    bal_pkg::cell_ctrl_t            ctrl;
    logic [bal_pkg::DATA_WIDTH-1:0] cell_data [bal_pkg::CAPACITY];

    logic                           accept;
    logic [bal_pkg::CMP_W-1:0]      pos_ext;
    logic [bal_pkg::CMP_W-1:0]      cnt_ext;
    logic [bal_pkg::CMP_W-1:0]      pos_less;
    logic                           full;
    bal_pkg::status_t               status;
    logic [bal_pkg::DATA_WIDTH-1:0] rd_data;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = bal_pkg::CMP_W'(request.position);
    assign cnt_ext = bal_pkg::CMP_W'(cnt_reg);
    assign pos_less = pos_ext - bal_pkg::CMP_W'(1);
    assign full    = (cnt_reg == bal_pkg::CNT_W'(bal_pkg::CAPACITY));

    always_comb
    begin
        ctrl.mode   = bal_pkg::CELL_HOLD;
        ctrl.target = pos_ext[bal_pkg::IDX_W-1:0];
        ctrl.data   = bal_pkg::DATA_WIDTH'(request.value);
        cnt_next    = cnt_reg;
        status      = bal_pkg::ST_OK;
        rd_data     = '0;
        case (request.op)
            bal_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status = bal_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.mode   = bal_pkg::CELL_APPEND;
                    ctrl.target = cnt_ext[bal_pkg::IDX_W-1:0];
                    cnt_next    = cnt_reg + bal_pkg::CNT_W'(1);
                end
            end
            bal_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status = bal_pkg::ST_FULL;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status = bal_pkg::ST_BADPOS;
                end
                else
                begin
                    ctrl.mode = bal_pkg::CELL_INSERT;
                    cnt_next  = cnt_reg + bal_pkg::CNT_W'(1);
                end
            end
            bal_pkg::OP_ERASE:
            begin
                if ((pos_ext == '0) || (pos_ext > cnt_ext))
                begin
                    status = bal_pkg::ST_BADPOS;
                end
                else
                begin
                    ctrl.mode   = bal_pkg::CELL_ERASE;
                    ctrl.target = pos_less[bal_pkg::IDX_W-1:0];
                    cnt_next    = cnt_reg - bal_pkg::CNT_W'(1);
                end
            end
            bal_pkg::OP_READ:
            begin
                if (cnt_reg == '0)
                begin
                    status = bal_pkg::ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status = bal_pkg::ST_BADPOS;
                end
                else
                begin
                    rd_data = cell_data[pos_ext[bal_pkg::IDX_W-1:0]];
                end
            end
            bal_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                status = bal_pkg::ST_OK;
            end
        endcase
        if (!accept)
        begin
            ctrl.mode = bal_pkg::CELL_HOLD;
            cnt_next  = cnt_reg;
        end
    end

    always_comb
    begin
        result_next.status     = status;
        result_next.read_value = bal_pkg::RDVAL_W'(rd_data);
        result_next.count      = bal_pkg::COUNT_W'(cnt_next);
    end

    for (genvar k = 0; k < bal_pkg::CAPACITY; k++)
    begin : g_cell
        logic [bal_pkg::DATA_WIDTH-1:0] left_data;
        logic [bal_pkg::DATA_WIDTH-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = ctrl.data;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[k-1];
        end

        if (k == bal_pkg::CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[k];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[k+1];
        end

        bal_cell u_cell (
            .clk        (clk),
            .index      (bal_pkg::IDX_W'(k)),
            .ctrl       (ctrl),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The entry count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bal_pkg::CNT_W'(bal_pkg::CAPACITY))
        else $error("entry count above capacity");

    // Every accepted request gives a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after request");

    // The reported count matches the stored count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count == bal_pkg::COUNT_W'(cnt_reg)))
        else $error("reported count differs from stored count");

    // A full status is only reported when the list is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == bal_pkg::ST_FULL)) |->
            (cnt_reg == bal_pkg::CNT_W'(bal_pkg::CAPACITY)))
        else $error("full status on a list below capacity");

endmodule
